// ----- hw/rtl/btlv_pkg.sv -----
// Package for the BER-TLV stream parser: beat structs, phase and event codes,
// and the EMV tag constants. No dependencies.
package btlv_pkg;

  // Field widths fixed by the interface
  localparam int BUF_LEN_W = 16;
  localparam int TAG_W     = 24;
  localparam int LACC_W    = 24;
  localparam int VLEN_W    = 16;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_LEN_OCTETS = 2'd0;
  localparam logic [1:0] ERR_OVERRUN    = 2'd1;
  localparam logic [1:0] ERR_INDEFINITE = 2'd2;

  // Byte-level constants
  localparam logic [4:0] TAG_MORE_MASK = 5'h1F;
  localparam logic [7:0] LEN_INDEF     = 8'h80;

  // Template (constructed) tags
  localparam logic [TAG_W-1:0] TAG_FCI_DISC  = 24'h00bf0c;
  localparam logic [TAG_W-1:0] TAG_APP_TMPL  = 24'h000061;
  localparam logic [TAG_W-1:0] TAG_FCI_TMPL  = 24'h00006f;
  localparam logic [TAG_W-1:0] TAG_REC_TMPL  = 24'h000070;
  localparam logic [TAG_W-1:0] TAG_RSP_TMPL  = 24'h000077;
  localparam logic [TAG_W-1:0] TAG_FCI_PROP  = 24'h0000a5;

  // Tag-length list tags
  localparam logic [TAG_W-1:0] TAG_PDOL      = 24'h009f38;
  localparam logic [TAG_W-1:0] TAG_LOG_ENTRY = 24'h009f4f;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TAG1  = 3'd1,
    PH_TAG2  = 3'd2,
    PH_TAG3  = 3'd3,
    PH_LEN1  = 3'd4,
    PH_LENX  = 3'd5,
    PH_VALUE = 3'd6
  } phase_t;

  // What a data beat produces
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_HEADER = 2'd1,
    EV_VALUE  = 2'd2,
    EV_ERROR  = 2'd3
  } evt_t;

  // Tag classification
  typedef struct packed {
    logic constructed;
    logic list_format;
  } tag_class_t;

  // Input beat
  typedef struct packed {
    logic                 command;
    logic [7:0]           byte_value;
    logic [BUF_LEN_W-1:0] buffer_length;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]        kind;
    logic [TAG_W-1:0]  tag_number;
    logic [1:0]        tag_size;
    logic [VLEN_W-1:0] value_length;
    logic              constructed;
    logic              list_format;
    logic [7:0]        data_out;
    logic              last_of_value;
    logic              buffer_done;
    logic [1:0]        error_code;
  } out_t;

endpackage

// ----- hw/rtl/btlv_tag_class.sv -----
// Tag classifier: flags template (constructed) tags and tag-length list tags.
// Depends on btlv_pkg.
module btlv_tag_class (
  input  logic [btlv_pkg::TAG_W-1:0] tag,
  output btlv_pkg::tag_class_t       cls
);
  import btlv_pkg::*;

  // compare against the fixed EMV tag set
  always_comb begin
    cls.constructed = (tag == TAG_FCI_DISC) || (tag == TAG_APP_TMPL) ||
                      (tag == TAG_FCI_TMPL) || (tag == TAG_REC_TMPL) ||
                      (tag == TAG_RSP_TMPL) || (tag == TAG_FCI_PROP);
    cls.list_format = (tag == TAG_PDOL) || (tag == TAG_LOG_ENTRY);
  end

endmodule

// ----- hw/rtl/ber_tlv_stream_parser.sv -----
// BER-TLV stream parser, top level. Depends on btlv_pkg and btlv_tag_class.
// Latency: a result appears in the cycle after the beat that causes it.
// Throughput: one input beat per cycle unless a held result stalls it; the
// parser state updates in the accepting cycle; the result register frees when taken.
// Reset (rst, synchronous, active high): phase idle, no buffer open, error
// latch clear, result register empty.
module ber_tlv_stream_parser #(
  parameter int MAX_LEN_OCTETS = 4,
  parameter int LENGTH_BITS    = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  btlv_pkg::in_t   item,
  output logic            result_valid,
  input  logic            result_ready,
  output btlv_pkg::out_t  result
);
  import btlv_pkg::*;

  // buffer counter keeps only the low bits of the length field
  localparam int RW = (LENGTH_BITS < BUF_LEN_W) ? LENGTH_BITS : BUF_LEN_W;
  localparam logic [7:0] MAX_OCT = 8'(MAX_LEN_OCTETS);

  // parser state
  phase_t             phase, phase_next;
  logic [RW-1:0]      bytes_remaining, bytes_remaining_next;
  logic [TAG_W-1:0]   tag_acc, tag_acc_next;
  logic [1:0]         tag_count, tag_count_next;
  logic [2:0]         len_left, len_left_next;
  logic [LACC_W-1:0]  len_acc, len_acc_next;
  logic [VLEN_W-1:0]  value_left, value_left_next;
  logic               err_latched, err_latched_next;

  // per-beat decode
  logic               accept;
  logic [7:0]         b;
  logic [RW-1:0]      br_dec;
  logic               check_end;
  logic               finish;
  logic               mismatch;
  evt_t               evt;
  logic [1:0]         ecode;
  tag_class_t         cls;
  out_t               result_next;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;
  assign b          = item.byte_value;
  assign br_dec     = bytes_remaining - RW'(1);

  btlv_tag_class u_tag_class (
    .tag (tag_acc),
    .cls (cls)
  );

  // next state
  always_comb begin
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    tag_acc_next         = tag_acc;
    tag_count_next       = tag_count;
    len_left_next        = len_left;
    len_acc_next         = len_acc;
    value_left_next      = value_left;
    err_latched_next     = err_latched;
    evt                  = EV_NONE;
    ecode                = ERR_LEN_OCTETS;
    check_end            = 1'b0;
    finish               = 1'b0;
    mismatch             = 1'b0;
    if (accept) begin
      if (item.command == CMD_START) begin
        // new buffer: everything restarts
        bytes_remaining_next = item.buffer_length[RW-1:0];
        tag_acc_next         = '0;
        tag_count_next       = '0;
        len_left_next        = '0;
        len_acc_next         = '0;
        value_left_next      = '0;
        err_latched_next     = 1'b0;
        phase_next = (item.buffer_length[RW-1:0] != '0) ? PH_TAG1 : PH_IDLE;
      end else if (phase == PH_IDLE || err_latched || bytes_remaining == '0) begin
        phase_next = PH_IDLE;
      end else begin
        bytes_remaining_next = br_dec;
        unique case (phase)
          PH_TAG1: begin
            tag_acc_next   = {16'h0000, b};
            tag_count_next = 2'd1;
            len_acc_next   = '0;
            len_left_next  = '0;
            phase_next     = (b[4:0] == TAG_MORE_MASK) ? PH_TAG2 : PH_LEN1;
            check_end      = 1'b1;
          end
          PH_TAG2: begin
            tag_acc_next   = {tag_acc[15:0], b};
            tag_count_next = 2'd2;
            phase_next     = b[7] ? PH_TAG3 : PH_LEN1;
            check_end      = 1'b1;
          end
          PH_TAG3: begin
            tag_acc_next   = {tag_acc[15:0], b};
            tag_count_next = 2'd3;
            phase_next     = PH_LEN1;
            check_end      = 1'b1;
          end
          PH_LEN1: begin
            if (b == LEN_INDEF) begin
              evt   = EV_ERROR;
              ecode = ERR_INDEFINITE;
            end else if (!b[7]) begin
              len_acc_next = {16'h0000, b};
              finish       = 1'b1;
            end else if (({1'b0, b[6:0]} + 8'd1) > MAX_OCT) begin
              evt   = EV_ERROR;
              ecode = ERR_LEN_OCTETS;
            end else begin
              len_left_next = b[2:0];
              len_acc_next  = '0;
              phase_next    = PH_LENX;
              check_end     = 1'b1;
            end
          end
          PH_LENX: begin
            len_acc_next  = {len_acc[15:0], b};
            len_left_next = len_left - 3'd1;
            if (len_left_next == 3'd0) begin
              finish = 1'b1;
            end else begin
              check_end = 1'b1;
            end
          end
          PH_VALUE: begin
            value_left_next = value_left - VLEN_W'(1);
            evt             = EV_VALUE;
            if (value_left_next == '0) begin
              phase_next = (br_dec != '0) ? PH_TAG1 : PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // buffer ran out inside a header
        if (check_end && br_dec == '0) begin
          evt   = EV_ERROR;
          ecode = ERR_OVERRUN;
        end

        // header complete: check the length against what is left
        if (finish) begin
          mismatch = cls.constructed ? (len_acc_next != LACC_W'(br_dec))
                                     : (len_acc_next >  LACC_W'(br_dec));
          if (mismatch) begin
            evt   = EV_ERROR;
            ecode = ERR_OVERRUN;
          end else begin
            evt = EV_HEADER;
            if (!cls.constructed && len_acc_next != '0) begin
              value_left_next = len_acc_next[VLEN_W-1:0];
              phase_next      = PH_VALUE;
            end else begin
              phase_next = (br_dec != '0) ? PH_TAG1 : PH_IDLE;
            end
          end
        end

        if (evt == EV_ERROR) begin
          phase_next       = PH_IDLE;
          err_latched_next = 1'b1;
        end
      end
    end
  end

  // result beat contents
  always_comb begin
    result_next = '0;
    case (evt)
      EV_HEADER: begin
        result_next.kind         = KIND_HEADER;
        result_next.tag_number   = tag_acc;
        result_next.tag_size     = tag_count;
        result_next.value_length = len_acc_next[VLEN_W-1:0];
        result_next.constructed  = cls.constructed;
        result_next.list_format  = cls.list_format;
        result_next.buffer_done  = (br_dec == '0);
      end
      EV_VALUE: begin
        result_next.kind          = KIND_VALUE;
        result_next.data_out      = b;
        result_next.last_of_value = (value_left_next == '0);
        result_next.buffer_done   = (br_dec == '0);
      end
      EV_ERROR: begin
        result_next.kind        = KIND_ERROR;
        result_next.error_code  = ecode;
        result_next.buffer_done = (br_dec == '0);
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bytes_remaining <= '0;
      tag_acc         <= '0;
      tag_count       <= '0;
      len_left        <= '0;
      len_acc         <= '0;
      value_left      <= '0;
      err_latched     <= 1'b0;
    end else begin
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      tag_acc         <= tag_acc_next;
      tag_count       <= tag_count_next;
      len_left        <= len_left_next;
      len_acc         <= len_acc_next;
      value_left      <= value_left_next;
      err_latched     <= err_latched_next;
    end
  end

  // result register: holds a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= (evt != EV_NONE);
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && evt != EV_NONE) begin
      result <= result_next;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for ber_tlv_stream_parser: directed and random TLV buffers,
// a beat-level parse predictor and an in-order result check. Depends on btlv_pkg.
module tb_top;
  import btlv_pkg::*;

  localparam int LEN_OCTETS_MAX = 4;
  localparam int BUF_BITS       = 16;
  localparam int CYCLE_LIMIT    = 100000;
  localparam int DRAIN_CYCLES   = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_t  item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  // Predictor state
  logic [15:0] buf_left;
  phase_t      parse_phase;
  logic [23:0] tag_bits;
  logic [1:0]  tag_len;
  logic [2:0]  len_octs_left;
  logic [23:0] len_bits;
  logic [15:0] value_left;
  logic        fault_held;
  out_t        parse_results[$];

  // Stimulus scratch and run statistics
  logic [7:0] frame[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int live_items = 0;
  int sent_items = 0;
  int fail_count = 0;
  int n_headers = 0;
  int n_values = 0;
  int n_errors = 0;
  int cycle_count = 0;

  ber_tlv_stream_parser #(
    .MAX_LEN_OCTETS(LEN_OCTETS_MAX),
    .LENGTH_BITS(BUF_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overall watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_template_tag(input logic [23:0] tag);
    return tag == TAG_FCI_DISC || tag == TAG_APP_TMPL || tag == TAG_FCI_TMPL ||
           tag == TAG_REC_TMPL || tag == TAG_RSP_TMPL || tag == TAG_FCI_PROP;
  endfunction

  function automatic out_t raise_fault(input logic [1:0] code);
    out_t r;
    r = '0;
    r.kind        = KIND_ERROR;
    r.buffer_done = (buf_left == 0);
    r.error_code  = code;
    fault_held    = 1'b1;
    parse_phase   = PH_IDLE;
    return r;
  endfunction

  // Header complete: check the length against the buffer and open the value
  function automatic out_t close_header();
    out_t r;
    logic tmpl;
    tmpl = is_template_tag(tag_bits);
    if (tmpl ? (len_bits != {8'h00, buf_left}) : (len_bits > {8'h00, buf_left}))
      return raise_fault(ERR_OVERRUN);
    r = '0;
    r.kind         = KIND_HEADER;
    r.tag_number   = tag_bits;
    r.tag_size     = tag_len;
    r.value_length = len_bits[15:0];
    r.constructed  = tmpl;
    r.list_format  = (tag_bits == TAG_PDOL || tag_bits == TAG_LOG_ENTRY);
    r.buffer_done  = (buf_left == 0);
    if (!tmpl && len_bits != 0) begin
      value_left  = len_bits[15:0];
      parse_phase = PH_VALUE;
    end else begin
      parse_phase = (buf_left != 0) ? PH_TAG1 : PH_IDLE;
    end
    return r;
  endfunction

  // Advance the parse by one accepted beat; returns 0 when the beat is ignored
  function automatic bit parse_beat(input in_t beat);
    out_t r;
    bit have;
    logic [7:0] b;
    r = '0;
    have = 1'b0;
    b = beat.byte_value;
    if (beat.command == CMD_START) begin
      buf_left      = beat.buffer_length;
      parse_phase   = (buf_left != 0) ? PH_TAG1 : PH_IDLE;
      tag_bits      = '0;
      tag_len       = '0;
      len_octs_left = '0;
      len_bits      = '0;
      value_left    = '0;
      fault_held    = 1'b0;
      return 1'b1;
    end
    if (parse_phase == PH_IDLE || fault_held || buf_left == 0) begin
      parse_phase = PH_IDLE;
      return 1'b0;
    end
    buf_left = buf_left - 16'd1;
    case (parse_phase)
      PH_TAG1: begin
        tag_bits      = {16'h0000, b};
        tag_len       = 2'd1;
        len_bits      = '0;
        len_octs_left = '0;
        parse_phase   = (b[4:0] == TAG_MORE_MASK) ? PH_TAG2 : PH_LEN1;
      end
      PH_TAG2: begin
        tag_bits    = {tag_bits[15:0], b};
        tag_len     = 2'd2;
        parse_phase = b[7] ? PH_TAG3 : PH_LEN1;
      end
      PH_TAG3: begin
        tag_bits    = {tag_bits[15:0], b};
        tag_len     = 2'd3;
        parse_phase = PH_LEN1;
      end
      PH_LEN1: begin
        if (b == LEN_INDEF) begin
          r = raise_fault(ERR_INDEFINITE);
          have = 1'b1;
        end else if (!b[7]) begin
          len_bits = {16'h0000, b};
          r = close_header();
          have = 1'b1;
        end else if (1 + int'(b[6:0]) > LEN_OCTETS_MAX) begin
          r = raise_fault(ERR_LEN_OCTETS);
          have = 1'b1;
        end else begin
          len_octs_left = b[2:0];
          len_bits      = '0;
          parse_phase   = PH_LENX;
        end
      end
      PH_LENX: begin
        len_bits      = {len_bits[15:0], b};
        len_octs_left = len_octs_left - 3'd1;
        if (len_octs_left == 0) begin
          r = close_header();
          have = 1'b1;
        end
      end
      PH_VALUE: begin
        value_left      = value_left - 16'd1;
        r.kind          = KIND_VALUE;
        r.data_out      = b;
        r.last_of_value = (value_left == 0);
        r.buffer_done   = (buf_left == 0);
        if (value_left == 0)
          parse_phase = (buf_left != 0) ? PH_TAG1 : PH_IDLE;
        have = 1'b1;
      end
      default: begin
        parse_phase = PH_IDLE;
        return 1'b1;
      end
    endcase
    // Buffer ran out before the header was complete
    if (!have && buf_left == 0) begin
      r = raise_fault(ERR_OVERRUN);
      have = 1'b1;
    end
    if (have)
      parse_results.push_back(r);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid && result_ready) begin
      if (parse_results.size() == 0) begin
        $error("result beat arrived with none predicted");
        fail_count++;
      end else begin
        want = parse_results.pop_front();
        case (want.kind)
          KIND_HEADER: n_headers++;
          KIND_VALUE:  n_values++;
          default:     n_errors++;
        endcase
        check_field("kind", 32'(want.kind), 32'(result.kind));
        check_field("tag_number", 32'(want.tag_number), 32'(result.tag_number));
        check_field("tag_size", 32'(want.tag_size), 32'(result.tag_size));
        check_field("value_length", 32'(want.value_length), 32'(result.value_length));
        check_field("constructed", 32'(want.constructed), 32'(result.constructed));
        check_field("list_format", 32'(want.list_format), 32'(result.list_format));
        check_field("data_out", 32'(want.data_out), 32'(result.data_out));
        check_field("last_of_value", 32'(want.last_of_value),
                    32'(result.last_of_value));
        check_field("buffer_done", 32'(want.buffer_done), 32'(result.buffer_done));
        check_field("error_code", 32'(want.error_code), 32'(result.error_code));
      end
    end
  end

  // Output side: random stalls, or a held-off stretch when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- driving

  // Offer one beat until taken, then maybe idle for a while
  task automatic send_beat(input in_t beat);
    int gap;
    gap = 0;
    item <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_items++;
    if (parse_beat(beat))
      live_items++;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_start(input logic [15:0] len);
    in_t beat;
    beat.command       = CMD_START;
    beat.byte_value    = 8'($urandom_range(255));
    beat.buffer_length = len;
    send_beat(beat);
  endtask

  task automatic send_data(input logic [7:0] b);
    in_t beat;
    beat.command       = CMD_DATA;
    beat.byte_value    = b;
    beat.buffer_length = 16'($urandom_range(65535));
    send_beat(beat);
  endtask

  task automatic send_frame(input int claim, input int count);
    send_start(16'(claim));
    for (int i = 0; i < count && i < frame.size(); i++)
      send_data(frame[i]);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (parse_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- buffer builder

  // Put tag and length in front of what the frame already holds
  task automatic prepend_header(input logic [23:0] tag, input int tsize,
                                input int unsigned len);
    int n;
    int minimal;
    logic [31:0] tmp;
    if (len < 128 && $urandom_range(3) != 0) begin
      tmp = len;
      frame.push_front(tmp[7:0]);
    end else begin
      minimal = (len < 256) ? 1 : 2;
      n = $urandom_range(LEN_OCTETS_MAX - 1, minimal);
      for (int i = 0; i < n; i++) begin
        tmp = len >> (8 * i);
        frame.push_front(tmp[7:0]);
      end
      tmp = 32'h80 | n;
      frame.push_front(tmp[7:0]);
    end
    for (int i = 0; i < tsize; i++) begin
      tmp = 32'(tag) >> (8 * i);
      frame.push_front(tmp[7:0]);
    end
  endtask

  task automatic pick_prim_tag(output logic [23:0] tag, output int tsize);
    int pick;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    pick = $urandom_range(9);
    if (pick == 0) begin
      tag = TAG_PDOL;
      tsize = 2;
    end else if (pick == 1) begin
      tag = TAG_LOG_ENTRY;
      tsize = 2;
    end else if (pick < 6) begin
      do b1 = 8'($urandom_range(255));
      while (b1[4:0] == TAG_MORE_MASK || is_template_tag({16'h0000, b1}));
      tag = {16'h0000, b1};
      tsize = 1;
    end else if (pick < 8) begin
      do begin
        b1 = {3'($urandom_range(7)), TAG_MORE_MASK};
        b2 = 8'($urandom_range(127));
      end while (is_template_tag({8'h00, b1, b2}));
      tag = {8'h00, b1, b2};
      tsize = 2;
    end else begin
      b1 = {3'($urandom_range(7)), TAG_MORE_MASK};
      b2 = 8'h80 | 8'($urandom_range(127));
      b3 = 8'($urandom_range(255));
      tag = {b1, b2, b3};
      tsize = 3;
    end
  endtask

  task automatic add_prims(input int count);
    logic [23:0] tag;
    int tsize;
    int vlen;
    repeat (count) begin
      vlen = ($urandom_range(24) == 0) ? $urandom_range(200, 120) : $urandom_range(6);
      repeat (vlen) frame.push_front(8'($urandom_range(255)));
      pick_prim_tag(tag, tsize);
      prepend_header(tag, tsize, vlen);
    end
  endtask

  // Well-formed buffer: primitives, optionally wrapped in nested templates that
  // run to the end of the buffer, optionally with more primitives ahead of a template
  task automatic build_frame();
    logic [23:0] tmpl;
    frame.delete();
    add_prims($urandom_range(3, 1));
    repeat ($urandom_range(2)) begin
      case ($urandom_range(5))
        0: tmpl = TAG_FCI_DISC;
        1: tmpl = TAG_APP_TMPL;
        2: tmpl = TAG_FCI_TMPL;
        3: tmpl = TAG_REC_TMPL;
        4: tmpl = TAG_RSP_TMPL;
        default: tmpl = TAG_FCI_PROP;
      endcase
      prepend_header(tmpl, (tmpl == TAG_FCI_DISC) ? 2 : 1, frame.size());
      if ($urandom_range(1) != 0)
        add_prims($urandom_range(2, 1));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // One- and three-byte tags, short and long length, empty value
  task automatic test_headers_and_values();
    send_start(16'd8);
    send_data(8'h5A);
    send_data(8'h01);
    send_data(8'hFF);
    send_data(8'hDF);
    send_data(8'h81);
    send_data(8'h01);
    send_data(8'h81);
    send_data(8'h00);
    wait_drained();
  endtask

  // Template holding a tag-length list tag with an empty value
  task automatic test_templates_and_lists();
    send_start(16'd5);
    send_data(TAG_APP_TMPL[7:0]);
    send_data(8'h03);
    send_data(TAG_PDOL[15:8]);
    send_data(TAG_PDOL[7:0]);
    send_data(8'h00);
    wait_drained();
  endtask

  task automatic test_error_cases();
    // indefinite length on the last buffer byte
    send_start(16'd2);
    send_data(8'h5A);
    send_data(LEN_INDEF);
    // value longer than the buffer
    send_start(16'd2);
    send_data(8'h5A);
    send_data(8'h05);
    // buffer ends inside a tag
    send_start(16'd1);
    send_data(TAG_PDOL[15:8]);
    // largest buffer, too many length octets, then an empty buffer and a stray byte
    send_start(16'hFFFF);
    send_data(8'h5A);
    send_data(8'h84);
    send_start(16'd0);
    send_data(8'h3C);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall,
                                     input int target);
    int first;
    int pick;
    int claim;
    int idx;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    first = live_items;
    while (live_items - first < target) begin
      build_frame();
      claim = frame.size();
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(claim, claim);
        if ($urandom_range(9) == 0)
          send_data(8'($urandom_range(255)));
      end else if (pick < 76) begin
        // claimed length short of the data
        send_frame($urandom_range(claim - 1), claim);
      end else if (pick < 84) begin
        // one damaged byte, often with the top bit set
        idx = $urandom_range(claim - 1);
        frame[idx] = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 128))
                                              : 8'($urandom_range(255));
        send_frame(claim, claim);
      end else if (pick < 90) begin
        // abandoned part way; the next start beat restarts
        send_frame(claim, $urandom_range(claim - 1));
      end else if (pick < 95) begin
        frame.delete();
        repeat ($urandom_range(12, 1)) frame.push_back(8'($urandom_range(255)));
        claim = ($urandom_range(1) != 0) ? frame.size() : $urandom_range(65535);
        send_frame(claim, frame.size());
      end else begin
        // claimed length longer than the data
        send_frame(claim + $urandom_range(4, 1), claim);
      end
    end
    wait_drained();
  endtask

  // Long output stall while a long value keeps coming in
  task automatic test_output_stall();
    send_idle_pct = 0;
    stall_pct = 0;
    frame.delete();
    repeat (60) frame.push_back(8'($urandom_range(255)));
    frame.push_front(8'd60);
    frame.push_front(8'h5A);
    hold_left = 200;
    send_frame(frame.size(), frame.size());
    wait_drained();
  endtask

  // Sender stops mid-buffer until every result so far has been taken
  task automatic test_pause_mid_buffer();
    int half;
    send_idle_pct = 22;
    stall_pct = 22;
    build_frame();
    half = frame.size() / 2;
    send_start(16'(frame.size()));
    for (int i = 0; i < half; i++)
      send_data(frame[i]);
    wait_drained();
    for (int i = half; i < frame.size(); i++)
      send_data(frame[i]);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_headers_and_values();
    test_templates_and_lists();
    test_error_cases();
    test_random_traffic(0, 0, 110);
    test_random_traffic(71, 0, 110);
    test_random_traffic(0, 71, 110);
    test_random_traffic(22, 22, 110);
    test_output_stall();
    test_pause_mid_buffer();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d input beats (%0d ignored by the parser) over four idle mixes",
             sent_items, sent_items - live_items);
    $display("and a long output stall; checked %0d headers, %0d value bytes, %0d errors.",
             n_headers, n_values, n_errors);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/btlv_pkg.sv
hw/rtl/btlv_tag_class.sv
hw/rtl/ber_tlv_stream_parser.sv
bench/tb_top.sv
